FILE: sv/fscp_pkg.sv
// shared types, constants and keyword table for the framed speed command parser
`default_nettype none

package fscp_pkg;

  localparam int BodyLenDef = 64;

  localparam int ByteW  = 8;
  localparam int SpeedW = 16;
  localparam int AccW   = 17;
  localparam int PosW   = 4;
  localparam int NumKw  = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [ByteW-1:0] StartMarkRst = 8'd60;
  localparam logic [ByteW-1:0] EndMarkRst   = 8'd62;
  localparam logic [ByteW-1:0] SepCharRst   = 8'd44;
  localparam logic signed [SpeedW-1:0] StopThrRst = 16'sd90;

  localparam logic [CfgIdxW-1:0] RegStartMark = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEndMark   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSepChar   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStopThr   = 2'd3;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_LEFT   = 3'd1,
    CMD_RIGHT  = 3'd2,
    CMD_BOTH   = 3'd3,
    CMD_INVERT = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    TOK_START = 2'd0,
    TOK_NAME  = 2'd1,
    TOK_GAP   = 2'd2,
    TOK_VALUE = 2'd3
  } tok_e;

  typedef enum logic [1:0] {
    NUM_IDLE   = 2'd0,
    NUM_SIGN   = 2'd1,
    NUM_DIGITS = 2'd2,
    NUM_DONE   = 2'd3
  } num_e;

  // keywords: value0, value1, carrinho, inverter
  localparam logic [ByteW-1:0] KwText [NumKw][8] = '{
    '{"v", "a", "l", "u", "e", "0", 8'h00, 8'h00},
    '{"v", "a", "l", "u", "e", "1", 8'h00, 8'h00},
    '{"c", "a", "r", "r", "i", "n", "h", "o"},
    '{"i", "n", "v", "e", "r", "t", "e", "r"}
  };
  localparam logic [PosW-1:0] KwLen [NumKw] = '{4'd6, 4'd6, 4'd8, 4'd8};

  typedef struct packed {
    logic [ByteW-1:0]         start_mark;
    logic [ByteW-1:0]         end_mark;
    logic [ByteW-1:0]         sep_char;
    logic signed [SpeedW-1:0] stop_thr;
  } cfg_t;

  typedef struct packed {
    logic             frame_done;
    cmd_e             command;
    logic [ByteW-1:0] left_duty;
    logic [ByteW-1:0] right_duty;
    logic             direction_forward;
    logic             motors_released;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/fscp_cfg.sv
// configuration registers: markers, separator and stop threshold
`default_nettype none

module fscp_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fscp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fscp_pkg::CfgDataW-1:0] cfg_data_i,
  output fscp_pkg::cfg_t                      cfg_o
);
  import fscp_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_mark <= StartMarkRst;
      cfg_q.end_mark   <= EndMarkRst;
      cfg_q.sep_char   <= SepCharRst;
      cfg_q.stop_thr   <= StopThrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegStartMark: cfg_q.start_mark <= cfg_data_i[ByteW-1:0];
        RegEndMark:   cfg_q.end_mark   <= cfg_data_i[ByteW-1:0];
        RegSepChar:   cfg_q.sep_char   <= cfg_data_i[ByteW-1:0];
        RegStopThr:   cfg_q.stop_thr   <= $signed(cfg_data_i[SpeedW-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: sv/fscp_core.sv
// parser state and single-pass update for one received byte
`default_nettype none

module fscp_core #(
  parameter int BodyLen = fscp_pkg::BodyLenDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic [fscp_pkg::ByteW-1:0] byte_i,
  input  wire fscp_pkg::cfg_t              cfg_i,
  output fscp_pkg::res_t                   res_o
);
  import fscp_pkg::*;

  localparam int CntW = $clog2(BodyLen);
  localparam logic [CntW-1:0] LastCnt = CntW'(BodyLen - 1);

  logic                     in_frame_q, in_frame_d;
  logic [CntW-1:0]          body_cnt_q, body_cnt_d;
  tok_e                     tok_q, tok_d;
  logic [PosW-1:0]          pos_q, pos_d;
  logic [NumKw-1:0]         kw_q, kw_d;
  logic [AccW-1:0]          acc_q, acc_d;
  logic                     neg_q, neg_d;
  num_e                     num_q, num_d;
  logic signed [SpeedW-1:0] left_q, left_d;
  logic signed [SpeedW-1:0] right_q, right_d;
  logic                     fwd_q, fwd_d;

  logic [NumKw-1:0]         kw_nm;
  logic [PosW-1:0]          pos_nm;
  logic [AccW-1:0]          acc_nm;
  logic                     neg_nm;
  num_e                     num_nm;
  logic [AccW+1:0]          acc_x10;
  logic                     is_digit, is_blank, is_sep;
  cmd_e                     cmd;
  logic signed [SpeedW-1:0] val;
  logic [AccW-1:0]          acc_neg;
  logic                     done, released;

  // keyword matching for one name character
  always_comb begin
    for (int k = 0; k < NumKw; k++) begin
      kw_nm[k] = kw_q[k] && (pos_q < KwLen[k]) && (KwText[k][pos_q[2:0]] == byte_i);
    end
    pos_nm = (pos_q == '1) ? pos_q : pos_q + 1'b1;
  end

  // atoi step for one value character
  always_comb begin
    is_digit = (byte_i >= "0") && (byte_i <= "9");
    is_blank = byte_i inside {[8'd9:8'd13], 8'h20};
    acc_x10  = ({2'b00, acc_q} << 3) + ({2'b00, acc_q} << 1)
             + (AccW+2)'(byte_i - "0");
    acc_nm   = acc_q;
    neg_nm   = neg_q;
    num_nm   = num_q;
    if (num_q != NUM_DONE) begin
      if (num_q == NUM_IDLE && is_blank) begin
        num_nm = num_q;
      end else if (num_q == NUM_IDLE && (byte_i == "-" || byte_i == "+")) begin
        neg_nm = (byte_i == "-");
        num_nm = NUM_SIGN;
      end else if (!is_digit) begin
        num_nm = NUM_DONE;
      end else begin
        acc_nm = (acc_x10 > (AccW+2)'(32768)) ? AccW'(32768) : acc_x10[AccW-1:0];
        num_nm = NUM_DIGITS;
      end
    end
  end

  // frame handling, command apply and release check
  always_comb begin
    in_frame_d = in_frame_q;
    body_cnt_d = body_cnt_q;
    tok_d      = tok_q;
    pos_d      = pos_q;
    kw_d       = kw_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    num_d      = num_q;
    left_d     = left_q;
    right_d    = right_q;
    fwd_d      = fwd_q;
    done       = 1'b0;
    released   = 1'b0;
    cmd        = CMD_NONE;
    is_sep     = (byte_i == cfg_i.sep_char);
    acc_neg    = ~acc_q + 1'b1;
    val        = '0;

    if (tok_q != TOK_START) begin
      for (int k = NumKw - 1; k >= 0; k--) begin
        if (kw_q[k] && pos_q == KwLen[k]) cmd = cmd_e'(3'(k + 1));
      end
    end
    if (tok_q == TOK_VALUE) begin
      if (neg_q) val = $signed(acc_neg[SpeedW-1:0]);
      else val = (acc_q > AccW'(32767)) ? 16'sh7fff : $signed(acc_q[SpeedW-1:0]);
    end

    if (in_frame_q) begin
      if (byte_i == cfg_i.end_mark) begin
        done = 1'b1;
        case (cmd)
          CMD_LEFT:   left_d = val;
          CMD_RIGHT:  right_d = val;
          CMD_BOTH: begin
            left_d  = val;
            right_d = val;
          end
          CMD_INVERT: fwd_d = !fwd_q;
          default: ;
        endcase
        in_frame_d = 1'b0;
        body_cnt_d = '0;
        tok_d      = TOK_START;
        pos_d      = '0;
        kw_d       = '1;
        acc_d      = '0;
        neg_d      = 1'b0;
        num_d      = NUM_IDLE;
      end else if (body_cnt_q < LastCnt) begin
        body_cnt_d = body_cnt_q + 1'b1;
        case (tok_q)
          TOK_START: begin
            if (!is_sep) begin
              tok_d = TOK_NAME;
              kw_d  = kw_nm;
              pos_d = pos_nm;
            end
          end
          TOK_NAME: begin
            if (is_sep) begin
              tok_d = TOK_GAP;
            end else begin
              kw_d  = kw_nm;
              pos_d = pos_nm;
            end
          end
          TOK_GAP: begin
            if (!is_sep) begin
              tok_d = TOK_VALUE;
              acc_d = acc_nm;
              neg_d = neg_nm;
              num_d = num_nm;
            end
          end
          default: begin
            if (is_sep) begin
              num_d = NUM_DONE;
            end else begin
              acc_d = acc_nm;
              neg_d = neg_nm;
              num_d = num_nm;
            end
          end
        endcase
      end
    end else if (byte_i == cfg_i.start_mark) begin
      in_frame_d = 1'b1;
      body_cnt_d = '0;
      tok_d      = TOK_START;
      pos_d      = '0;
      kw_d       = '1;
      acc_d      = '0;
      neg_d      = 1'b0;
      num_d      = NUM_IDLE;
    end

    if (left_d < cfg_i.stop_thr && right_d < cfg_i.stop_thr) begin
      left_d   = '0;
      right_d  = '0;
      released = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      body_cnt_q <= '0;
      tok_q      <= TOK_START;
      pos_q      <= '0;
      kw_q       <= '1;
      acc_q      <= '0;
      neg_q      <= 1'b0;
      num_q      <= NUM_IDLE;
      left_q     <= '0;
      right_q    <= '0;
      fwd_q      <= 1'b0;
    end else if (en_i) begin
      in_frame_q <= in_frame_d;
      body_cnt_q <= body_cnt_d;
      tok_q      <= tok_d;
      pos_q      <= pos_d;
      kw_q       <= kw_d;
      acc_q      <= acc_d;
      neg_q      <= neg_d;
      num_q      <= num_d;
      left_q     <= left_d;
      right_q    <= right_d;
      fwd_q      <= fwd_d;
    end
  end

  always_comb begin
    res_o.frame_done        = done;
    res_o.command           = done ? cmd : CMD_NONE;
    res_o.left_duty         = left_d[ByteW-1:0];
    res_o.right_duty        = right_d[ByteW-1:0];
    res_o.direction_forward = fwd_d;
    res_o.motors_released   = released;
  end

endmodule

`default_nettype wire

FILE: sv/framed_speed_command_parser.sv
// top level: input register, parser core and result register
//
// Received bytes enter on the input channel (in_valid_i, in_stall_o, rx_byte_i),
// one request per byte. Every byte gives exactly one result on the output
// channel (out_valid_o, out_stall_i): frame_done_o and command_o flag the byte
// that closed a frame, the duty, direction and release outputs show the
// motor state after that byte.
// A byte is held in the input register until the parser can advance, and its
// result is then written to the result register, which drives out_valid_o.
// One byte per cycle is sustained while the receiver does not stall; the parser
// state update sits between the two registers.
// While the receiver stalls a valid result, the byte in the input register
// waits and in_stall_o rises once that register is full.
// Reset clears both valid flags, the parser state, the speeds and the
// direction, and loads the register defaults ('<', '>', ',', threshold 90).
// Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must do so while no request is in flight, which the block does not enforce.
`default_nettype none

module framed_speed_command_parser #(
  parameter int BodyLen = fscp_pkg::BodyLenDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fscp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fscp_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [fscp_pkg::ByteW-1:0]    rx_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                frame_done_o,
  output logic [2:0]                          command_o,
  output logic [fscp_pkg::ByteW-1:0]         left_duty_o,
  output logic [fscp_pkg::ByteW-1:0]         right_duty_o,
  output logic                                direction_forward_o,
  output logic                                motors_released_o
);
  import fscp_pkg::*;

  cfg_t             cfg;
  res_t             res_d, res_q;
  logic             in_valid_q, out_valid_q;
  logic [ByteW-1:0] rx_q;
  logic             advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  fscp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  fscp_core #(
    .BodyLen (BodyLen)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .byte_i (rx_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      rx_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign frame_done_o        = res_q.frame_done;
  assign command_o           = res_q.command;
  assign left_duty_o         = res_q.left_duty;
  assign right_duty_o        = res_q.right_duty;
  assign direction_forward_o = res_q.direction_forward;
  assign motors_released_o   = res_q.motors_released;

endmodule

`default_nettype wire

FILE: sv/fscp_checker.sv
// port-level checks for the framed speed command parser, bound to the top level
`default_nettype none

module fscp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       frame_done_o,
  input wire logic [2:0] command_o,
  input wire logic [7:0] left_duty_o,
  input wire logic [7:0] right_duty_o,
  input wire logic       motors_released_o
);
  import fscp_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted request shows a result once it has passed the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("no result after accepted request");

  // only a closing byte carries a command
  a_cmd_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> command_o == CMD_NONE)
    else $error("command outside frame close");

  // released motors show zero duty
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motors_released_o |-> left_duty_o == 8'd0 && right_duty_o == 8'd0)
    else $error("duty not zero on release");

endmodule

bind framed_speed_command_parser fscp_checker u_fscp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .frame_done_o      (frame_done_o),
  .command_o         (command_o),
  .left_duty_o       (left_duty_o),
  .right_duty_o      (right_duty_o),
  .motors_released_o (motors_released_o)
);

`default_nettype wire

FILE: verif/fscp_command_checker.sv
// checker that predicts each parser result from the accepted requests and compares it
`timescale 1ns / 1ps

module fscp_command_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fscp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fscp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [fscp_pkg::ByteW-1:0]    rx_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           frame_done_i,
  input  logic [2:0]                     command_i,
  input  logic [fscp_pkg::ByteW-1:0]    left_duty_i,
  input  logic [fscp_pkg::ByteW-1:0]    right_duty_i,
  input  logic                           direction_forward_i,
  input  logic                           motors_released_i,
  output int                             mismatch_cnt_o,
  output int                             due_cnt_o
);
  import fscp_pkg::*;

  logic [ByteW-1:0] start_mark;
  logic [ByteW-1:0] end_mark;
  logic [ByteW-1:0] sep_char;
  int               stop_level;

  logic             in_frame;
  int               body_cnt;
  tok_e             tok_phase;
  int               name_pos;
  logic [NumKw-1:0] kw_live;
  int               num_acc;
  logic             num_neg;
  num_e             num_phase;
  int               left_spd;
  int               right_spd;
  logic             fwd;

  res_t due_results[$];
  int   mismatches = 0;
  int   due_size = 0;

  assign mismatch_cnt_o = mismatches;
  assign due_cnt_o      = due_size;

  function automatic void restart_parse();
    body_cnt  = 0;
    tok_phase = TOK_START;
    name_pos  = 0;
    kw_live   = '1;
    num_acc   = 0;
    num_neg   = 1'b0;
    num_phase = NUM_IDLE;
  endfunction

  function automatic void match_name(input logic [ByteW-1:0] c);
    for (int k = 0; k < NumKw; k++) begin
      if (kw_live[k] && (name_pos >= int'(KwLen[k]) || KwText[k][name_pos % 8] != c)) begin
        kw_live[k] = 1'b0;
      end
    end
    if (name_pos < 15) name_pos++;
  endfunction

  function automatic void read_number(input logic [ByteW-1:0] c);
    if (num_phase == NUM_DONE) return;
    if (num_phase == NUM_IDLE) begin
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
      if (c == "-" || c == "+") begin
        num_neg   = (c == "-");
        num_phase = NUM_SIGN;
        return;
      end
    end
    if (c < "0" || c > "9") begin
      num_phase = NUM_DONE;
      return;
    end
    num_acc = num_acc * 10 + int'(c - "0");
    if (num_acc > 32768) num_acc = 32768;
    num_phase = NUM_DIGITS;
  endfunction

  function automatic void take_body(input logic [ByteW-1:0] c);
    logic is_sep;
    is_sep = (c == sep_char);
    case (tok_phase)
      TOK_START: if (!is_sep) begin
        tok_phase = TOK_NAME;
        match_name(c);
      end
      TOK_NAME: if (is_sep) tok_phase = TOK_GAP;
        else match_name(c);
      TOK_GAP: if (!is_sep) begin
        tok_phase = TOK_VALUE;
        read_number(c);
      end
      default: if (is_sep) num_phase = NUM_DONE;
        else read_number(c);
    endcase
  endfunction

  function automatic cmd_e close_frame();
    cmd_e cmd;
    int   val;
    cmd = CMD_NONE;
    val = 0;
    // lowest keyword index wins
    if (tok_phase != TOK_START) begin
      for (int k = NumKw - 1; k >= 0; k--) begin
        if (kw_live[k] && name_pos == int'(KwLen[k])) cmd = cmd_e'(k + 1);
      end
    end
    if (tok_phase == TOK_VALUE) begin
      if (num_neg) val = -num_acc;
      else val = (num_acc > 32767) ? 32767 : num_acc;
    end
    case (cmd)
      CMD_LEFT:   left_spd = val;
      CMD_RIGHT:  right_spd = val;
      CMD_BOTH: begin
        left_spd  = val;
        right_spd = val;
      end
      CMD_INVERT: fwd = !fwd;
      default: ;
    endcase
    return cmd;
  endfunction

  function automatic res_t parse_byte(input logic [ByteW-1:0] c);
    res_t r;
    logic done;
    logic released;
    cmd_e cmd;
    done     = 1'b0;
    released = 1'b0;
    cmd      = CMD_NONE;
    if (in_frame) begin
      if (c == end_mark) begin
        cmd      = close_frame();
        done     = 1'b1;
        in_frame = 1'b0;
        restart_parse();
      end else if (body_cnt < BodyLenDef - 1) begin
        take_body(c);
        body_cnt++;
      end
    end else if (c == start_mark) begin
      in_frame = 1'b1;
      restart_parse();
    end
    if (left_spd < stop_level && right_spd < stop_level) begin
      left_spd  = 0;
      right_spd = 0;
      released  = 1'b1;
    end
    r.frame_done        = done;
    r.command           = cmd;
    r.left_duty         = left_spd[ByteW-1:0];
    r.right_duty        = right_spd[ByteW-1:0];
    r.direction_forward = fwd;
    r.motors_released   = released;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t want;
    if (!rst_ni) begin
      start_mark = StartMarkRst;
      end_mark   = EndMarkRst;
      sep_char   = SepCharRst;
      stop_level = int'(StopThrRst);
      in_frame   = 1'b0;
      restart_parse();
      left_spd   = 0;
      right_spd  = 0;
      fwd        = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegStartMark: start_mark = cfg_data_i[ByteW-1:0];
          RegEndMark:   end_mark = cfg_data_i[ByteW-1:0];
          RegSepChar:   sep_char = cfg_data_i[ByteW-1:0];
          RegStopThr:   stop_level = int'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) due_results.push_back(parse_byte(rx_byte_i));
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result with no request pending");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("frame_done", want.frame_done, frame_done_i);
          check_field("command", want.command, command_i);
          check_field("left_duty", want.left_duty, left_duty_i);
          check_field("right_duty", want.right_duty, right_duty_i);
          check_field("direction_forward", want.direction_forward, direction_forward_i);
          check_field("motors_released", want.motors_released, motors_released_i);
        end
      end
    end
    due_size = due_results.size();
  end

endmodule

FILE: verif/tb.sv
// testbench top: drives bytes and register writes into the parser and reports the verdict
`timescale 1ns / 1ps

module tb;
  import fscp_pkg::*;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BLOCK
  } stall_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = RegStartMark;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic [ByteW-1:0]    rx_byte = '0;
  logic                out_stall = 1'b0;

  logic             in_stall;
  logic             out_valid;
  logic             frame_done;
  logic [2:0]       command;
  logic [ByteW-1:0] left_duty;
  logic [ByteW-1:0] right_duty;
  logic             direction_forward;
  logic             motors_released;
  int               mismatch_cnt;
  int               due_cnt;

  logic [ByteW-1:0] start_mark = StartMarkRst;
  logic [ByteW-1:0] end_mark = EndMarkRst;
  logic [ByteW-1:0] sep_char = SepCharRst;
  logic [ByteW-1:0] frame_q[$];
  int               burst_left = 0;
  stall_e           stall_mode = STALL_NONE;
  int               stall_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  framed_speed_command_parser i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .rx_byte_i           (rx_byte),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .frame_done_o        (frame_done),
    .command_o           (command),
    .left_duty_o         (left_duty),
    .right_duty_o        (right_duty),
    .direction_forward_o (direction_forward),
    .motors_released_o   (motors_released)
  );

  fscp_command_checker i_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .rx_byte_i           (rx_byte),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .frame_done_i        (frame_done),
    .command_i           (command),
    .left_duty_i         (left_duty),
    .right_duty_i        (right_duty),
    .direction_forward_i (direction_forward),
    .motors_released_i   (motors_released),
    .mismatch_cnt_o      (mismatch_cnt),
    .due_cnt_o           (due_cnt)
  );

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_e'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 64);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
      default:     out_stall <= (stall_left % 8 < 5);
    endcase
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  // upper byte of the narrow registers is junk and must be ignored
  task automatic set_regs(input logic [ByteW-1:0] s, e, p, input logic [CfgDataW-1:0] thr);
    write_reg(RegStartMark, {8'($urandom), s});
    write_reg(RegEndMark, {8'($urandom), e});
    write_reg(RegSepChar, {8'($urandom), p});
    write_reg(RegStopThr, thr);
    cfg_we     <= 1'b0;
    start_mark = s;
    end_mark   = e;
    sep_char   = p;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_cnt != 0) @(negedge clk);
  endtask

  function automatic logic [ByteW-1:0] body_safe(input logic [ByteW-1:0] b);
    return (b == end_mark) ? (b ^ 8'h01) : b;
  endfunction

  task automatic queue_frame();
    int               kw;
    int               n;
    logic [ByteW-1:0] b;
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) begin
      b = 8'($urandom);
      if (b == start_mark && $urandom_range(0, 3) != 0) b = b ^ 8'h01;
      frame_q.push_back(b);
    end
    frame_q.push_back(start_mark);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) frame_q.push_back(sep_char);
    kw = $urandom_range(0, NumKw - 1);
    n  = $urandom_range(0, 9);
    if (n < 7) begin
      for (int i = 0; i < int'(KwLen[kw]); i++) frame_q.push_back(KwText[kw][i]);
    end else if (n == 7) begin
      // clipped or overlong keyword
      n = $urandom_range(1, int'(KwLen[kw]) + 1);
      for (int i = 0; i < n; i++) begin
        frame_q.push_back((i < int'(KwLen[kw])) ? KwText[kw][i % 8] : body_safe(8'($urandom)));
      end
    end else if (n == 8) begin
      repeat ($urandom_range(1, 9)) frame_q.push_back(body_safe(8'($urandom)));
    end
    if ($urandom_range(0, 5) != 0) begin
      repeat (($urandom_range(0, 5) == 0) ? 2 : 1) frame_q.push_back(sep_char);
      if ($urandom_range(0, 4) == 0) begin
        frame_q.push_back(($urandom_range(0, 1) == 0) ? 8'h20 : 8'($urandom_range(9, 13)));
      end
      n = $urandom_range(0, 5);
      if (n < 2) frame_q.push_back("-");
      else if (n == 2) frame_q.push_back("+");
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
      repeat (n) frame_q.push_back(8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 6) == 0) frame_q.push_back(body_safe(8'($urandom)));
      if ($urandom_range(0, 6) == 0) begin
        frame_q.push_back(sep_char);
        frame_q.push_back(8'("0" + $urandom_range(0, 9)));
      end
    end
    // overlong body
    if ($urandom_range(0, 14) == 0) begin
      repeat ($urandom_range(56, 70)) frame_q.push_back(8'("a" + $urandom_range(0, 25)));
    end
    if ($urandom_range(0, 11) != 0) frame_q.push_back(end_mark);
  endtask

  task automatic run_phase(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      queue_frame();
      sent += frame_q.size();
      foreach (frame_q[i]) send_byte(frame_q[i]);
      frame_q.delete();
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("<value1, +99999,7>");
    send_text("<value0>");
    send_text("<carrinho,-9>");
    send_text("<inverter>");
    send_byte(StartMarkRst);
    send_byte(SepCharRst);
    send_byte(StartMarkRst);
    send_byte(8'h00);
    send_byte(EndMarkRst);
    run_phase(80);

    settle();
    set_regs(8'h00, 8'hFF, 8'h00, 16'h7FFF);
    run_phase(60);
    settle();
    set_regs(8'hFF, 8'h00, 8'hFF, 16'h8000);
    run_phase(70);
    settle();
    set_regs("#", "#", "5", 16'h0000);
    run_phase(60);
    settle();
    set_regs(StartMarkRst, EndMarkRst, 8'h20, 16'hFFFF);
    run_phase(60);
    settle();
    set_regs("[", "]", ";", 16'd200);
    run_phase(80);

    settle();
    repeat (6) @(negedge clk);
    if (mismatch_cnt == 0 && due_cnt == 0) begin
      $display("framed_speed_command_parser regression: pass");
    end else begin
      $display("framed_speed_command_parser regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("framed_speed_command_parser regression: fail");
    $finish;
  end

endmodule
